// ===== rtl/glyph_index_table_assert.svh =====
// Assertion macros used by the checker file of the glyph index table.
`ifndef GLYPH_INDEX_TABLE_ASSERT_SVH
`define GLYPH_INDEX_TABLE_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define GIDX_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("glyph index table check failed");

// Condition that must never be seen outside reset.
`define GIDX_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("glyph index table forbidden condition seen");

`endif

// ===== rtl/gidx_pkg.sv =====
package gidx_pkg;

  localparam int CODE_W   = 21;
  localparam int DIM_W    = 15;
  localparam int MET_W    = 16;
  localparam int IDX_W    = 8;
  localparam int STATUS_W = 3;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_INVALID = 3'd3,
    ST_READ    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_RD_ISSUE = 3'd1,
    S_RD_DATA  = 3'd2,
    S_SCAN     = 3'd3,
    S_DONE     = 3'd4
  } ctrl_state_e;

  typedef struct packed {
    logic [CODE_W-1:0]        code;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic signed [MET_W-1:0]  bear_h;
    logic signed [MET_W-1:0]  bear_v;
    logic signed [MET_W-1:0]  adv_h;
    logic signed [MET_W-1:0]  adv_v;
  } entry_t;

  typedef struct packed {
    logic    load;
    logic    rd_issue;
    logic    scan_issue;
    logic    insert;
    logic    finish;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic code_zero;
    logic hit;
    logic more;
    logic full;
    logic ridx_ok;
  } stat_t;

endpackage

// ===== rtl/gidx_ctrl.sv =====
module gidx_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             opcode_i,
  input  gidx_pkg::stat_t  stat_i,
  output gidx_pkg::cmd_t   cmd_o,
  output logic             busy,
  output logic             done_o
);
  import gidx_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '{load: 1'b0, rd_issue: 1'b0, scan_issue: 1'b0, insert: 1'b0,
                finish: 1'b0, status: ST_INVALID};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = (opcode_i == OP_READ) ? S_RD_ISSUE : S_SCAN;
        end
      end
      S_RD_ISSUE: begin
        if (stat_i.ridx_ok) begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_RD_DATA;
        end else begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_INVALID;
          state_d      = S_DONE;
        end
      end
      S_RD_DATA: begin
        cmd_o.finish = 1'b1;
        cmd_o.status = ST_READ;
        state_d      = S_DONE;
      end
      S_SCAN: begin
        if (stat_i.code_zero) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_INVALID;
          state_d      = S_DONE;
        end else if (stat_i.hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_PRESENT;
          state_d      = S_DONE;
        end else if (stat_i.more) begin
          cmd_o.scan_issue = 1'b1;
        end else if (stat_i.full) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_FULL;
          state_d      = S_DONE;
        end else begin
          cmd_o.insert = 1'b1;
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_ADDED;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== rtl/gidx_dp.sv =====
module gidx_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gidx_pkg::cmd_t                       cmd_i,
  output gidx_pkg::stat_t                      stat_o,
  input  logic                                 opcode_i,
  input  logic [gidx_pkg::CODE_W-1:0]          char_code_i,
  input  logic [gidx_pkg::IDX_W-1:0]           read_index_i,
  input  logic [gidx_pkg::DIM_W-1:0]           glyph_width_i,
  input  logic [gidx_pkg::DIM_W-1:0]           glyph_height_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    bearing_x_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    bearing_y_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    advance_x_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    advance_y_i,
  output gidx_pkg::status_e                    status_o,
  output logic [gidx_pkg::IDX_W-1:0]           entry_index_o,
  output logic [gidx_pkg::CODE_W-1:0]          out_code_o,
  output logic [gidx_pkg::DIM_W-1:0]           out_width_o,
  output logic [gidx_pkg::DIM_W-1:0]           out_height_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_bearing_x_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_bearing_y_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_advance_x_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_advance_y_o
);
  import gidx_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;
  entry_t item_q;

  logic              op_q;
  logic [IDX_W-1:0]  ridx_q;
  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic              pv_q;
  logic [AW-1:0]     pidx_q;
  logic [AW-1:0]     rd_addr;

  status_e           res_status_d, res_status_q;
  logic [IDX_W-1:0]  res_idx_d, res_idx_q;
  entry_t            res_data_d, res_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      ptr_q   <= ptr_d;
      pv_q    <= cmd_i.scan_issue;
    end
  end

  always_comb begin
    count_d = count_q;
    ptr_d   = ptr_q;
    if (cmd_i.load) begin
      ptr_d = '0;
    end else if (cmd_i.scan_issue) begin
      ptr_d = ptr_q + 1'b1;
    end
    if (cmd_i.insert) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      ridx_q <= read_index_i;
      item_q <= '{code: char_code_i, width: glyph_width_i, height: glyph_height_i,
                  bear_h: bearing_x_i, bear_v: bearing_y_i,
                  adv_h: advance_x_i, adv_v: advance_y_i};
    end
    if (cmd_i.scan_issue) begin
      pidx_q <= ptr_q[AW-1:0];
    end
  end

  assign rd_addr = cmd_i.rd_issue ? AW'(ridx_q) : ptr_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      mem_q[count_q[AW-1:0]] <= item_q;
    end
    if (cmd_i.rd_issue || cmd_i.scan_issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign stat_o.code_zero = (item_q.code == '0);
  assign stat_o.hit       = pv_q && (rdata_q.code == item_q.code);
  assign stat_o.more      = (ptr_q < count_q);
  assign stat_o.full      = (count_q == CW'(TABLE_DEPTH));
  assign stat_o.ridx_ok   = (CMPW'(ridx_q) < CMPW'(count_q));

  always_comb begin
    res_status_d = cmd_i.status;
    res_idx_d    = '0;
    res_data_d   = '0;
    case (cmd_i.status)
      ST_ADDED:   res_idx_d = IDX_W'(count_q);
      ST_PRESENT: res_idx_d = IDX_W'(pidx_q);
      ST_READ: begin
        res_idx_d  = ridx_q;
        res_data_d = rdata_q;
      end
      ST_INVALID: res_idx_d = (op_q == OP_READ) ? ridx_q : '0;
      default:    res_idx_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_status_q <= res_status_d;
      res_idx_q    <= res_idx_d;
      res_data_q   <= res_data_d;
    end
  end

  assign status_o        = res_status_q;
  assign entry_index_o   = res_idx_q;
  assign out_code_o      = res_data_q.code;
  assign out_width_o     = res_data_q.width;
  assign out_height_o    = res_data_q.height;
  assign out_bearing_x_o = res_data_q.bear_h;
  assign out_bearing_y_o = res_data_q.bear_v;
  assign out_advance_x_o = res_data_q.adv_h;
  assign out_advance_y_o = res_data_q.adv_v;

endmodule

// ===== rtl/glyph_index_table.sv =====
// Table of character codes with six glyph metrics per entry, filled from index 0 upward.
// An item is taken when start is high and busy is low, and every item gives exactly one
// result, shown for one cycle while done_o is high; the receiver cannot stall, so it must
// take the result in that cycle. A read item issues one read of the entry memory before
// its result, and is reported invalid without a read when its index is not below the fill
// count. An add item scans the filled entries through the single read port of the entry
// memory, one entry per cycle, so its scan grows with the fill count; it ends early when the
// code is found and without a scan for a zero code. A full table or a zero code is reported
// and leaves the table unchanged.
module glyph_index_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  output logic                                 done_o,
  input  logic                                 opcode_i,
  input  logic [gidx_pkg::CODE_W-1:0]          char_code_i,
  input  logic [gidx_pkg::IDX_W-1:0]           read_index_i,
  input  logic [gidx_pkg::DIM_W-1:0]           glyph_width_i,
  input  logic [gidx_pkg::DIM_W-1:0]           glyph_height_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    bearing_x_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    bearing_y_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    advance_x_i,
  input  logic signed [gidx_pkg::MET_W-1:0]    advance_y_i,
  output gidx_pkg::status_e                    status_o,
  output logic [gidx_pkg::IDX_W-1:0]           entry_index_o,
  output logic [gidx_pkg::CODE_W-1:0]          out_code_o,
  output logic [gidx_pkg::DIM_W-1:0]           out_width_o,
  output logic [gidx_pkg::DIM_W-1:0]           out_height_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_bearing_x_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_bearing_y_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_advance_x_o,
  output logic signed [gidx_pkg::MET_W-1:0]    out_advance_y_o
);
  import gidx_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  gidx_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  gidx_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .char_code_i     (char_code_i),
    .read_index_i    (read_index_i),
    .glyph_width_i   (glyph_width_i),
    .glyph_height_i  (glyph_height_i),
    .bearing_x_i     (bearing_x_i),
    .bearing_y_i     (bearing_y_i),
    .advance_x_i     (advance_x_i),
    .advance_y_i     (advance_y_i),
    .status_o        (status_o),
    .entry_index_o   (entry_index_o),
    .out_code_o      (out_code_o),
    .out_width_o     (out_width_o),
    .out_height_o    (out_height_o),
    .out_bearing_x_o (out_bearing_x_o),
    .out_bearing_y_o (out_bearing_y_o),
    .out_advance_x_o (out_advance_x_o),
    .out_advance_y_o (out_advance_y_o)
  );

endmodule

// ===== rtl/gidx_checker.sv =====
`include "glyph_index_table_assert.svh"

module gidx_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 done_o,
  input gidx_pkg::status_e                    status_o,
  input logic [gidx_pkg::IDX_W-1:0]           entry_index_o,
  input logic [gidx_pkg::CODE_W-1:0]          out_code_o,
  input logic [gidx_pkg::DIM_W-1:0]           out_width_o,
  input logic signed [gidx_pkg::MET_W-1:0]    out_advance_y_o
);
  import gidx_pkg::*;

  // An accepted item keeps the block occupied until its result has gone out.
  `GIDX_ASSERT(a_accept_busy, start && !busy |=> busy)

  // A result is only shown while an item is still in flight.
  `GIDX_ASSERT_NEVER(a_done_idle, done_o && !busy)

  // Each item gives a single one-cycle strobe.
  `GIDX_ASSERT(a_single_strobe, done_o |=> !done_o)

  // Only a successful read carries stored data.
  `GIDX_ASSERT(a_data_zero, done_o && status_o != ST_READ |->
    out_code_o == '0 && out_width_o == '0 && out_advance_y_o == '0)

  // A full table reports index zero.
  `GIDX_ASSERT(a_full_index, done_o && status_o == ST_FULL |-> entry_index_o == '0)

endmodule

bind glyph_index_table gidx_checker u_gidx_checker (.*);
